// ----- hw/rtl/sorted_key_table_insert_search_unit_macros.svh -----
// Assertion macros shared by the checker of the sorted key table.
`ifndef SORTED_KEY_TABLE_INSERT_SEARCH_UNIT_MACROS_SVH
`define SORTED_KEY_TABLE_INSERT_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SKTIS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SKTIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/sktis_pkg.sv -----
// Types and constants of the sorted key table insert and search unit.
package sktis_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int KEY_W         = 30;
    localparam int HANDLE_W      = 16;
    localparam int POS_W         = 7;
    localparam int STATUS_W      = 3;
    localparam int S_TDATA_W     = 48;
    localparam int M_TDATA_W     = 32;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_FOUND     = 3'd3,
        STAT_MISSING   = 3'd4
    } status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_CHECK_RD,
        S_CHECK,
        S_SHIFT,
        S_RESULT
    } state_t;

endpackage

// ----- hw/rtl/sktis_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sktis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/sorted_key_table_insert_search_unit.sv -----
// Each transaction runs a binary search over the n records held, then reads the lower bound to
// check for a hit; an insert moves the records at and above its position up a slot, top first, and
// writes it. A new transaction waits until the last is done; all reads share one RAM read port.
// A finished result waits in the output register while the next transaction is taken.
// Reset empties the table at once; the RAM contents are not cleared and need no pass.
module sorted_key_table_insert_search_unit
    import sktis_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // search_key[29:0], record_handle[45:30]
    input  logic                 s_tuser,   // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // found_handle[15:0], position[22:16],
                                            // entry_count[29:23]
    output logic [STATUS_W-1:0]  m_tuser    // status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int RW = KEY_W + HANDLE_W;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [HANDLE_W-1:0]   hnd_reg, hnd_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic [CW-1:0]         lo_reg, lo_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic [CW-1:0]         mid_reg, mid_next;
    logic [CW-1:0]         ptr_reg, ptr_next;
    logic                  pend_reg, pend_next;
    logic                  inrange_reg, inrange_next;
    status_t               res_status_reg, res_status_next;
    logic [HANDLE_W-1:0]   res_handle_reg, res_handle_next;
    logic [POS_W-1:0]      res_pos_reg, res_pos_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_user_reg, out_user_next;
    logic [M_TDATA_W-1:0]  out_data_reg, out_data_next;

    logic [CW-1:0]         mid;
    logic [CW-1:0]         ptr_inc;
    logic [CW-1:0]         ptr_dec;
    logic                  hit;
    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [RW-1:0]         ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [RW-1:0]         ram_rd_data;
    logic [KEY_W-1:0]      rd_key;
    logic [HANDLE_W-1:0]   rd_hnd;

    // Each RAM word holds the handle above the key.
    sktis_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_key  = ram_rd_data[KEY_W-1:0];
    assign rd_hnd  = ram_rd_data[RW-1:KEY_W];
    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign ptr_inc = ptr_reg + CW'(1);
    assign ptr_dec = ptr_reg - CW'(1);
    assign hit     = inrange_reg && (rd_key == key_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                state_next = (lo_reg < hi_reg) ? S_CMP : S_CHECK_RD;
            end
            S_CMP:
            begin
                state_next = S_PROBE;
            end
            S_CHECK_RD:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (op_reg == OP_LOOKUP || hit || fill_reg == CW'(DEPTH))
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (ptr_reg == lo_reg && !pend_reg)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        hnd_next        = hnd_reg;
        fill_next       = fill_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        ptr_next        = ptr_reg;
        pend_next       = pend_reg;
        inrange_next    = inrange_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_pos_next    = res_pos_reg;
        out_valid_next  = out_valid_reg;
        out_user_next   = out_user_reg;
        out_data_next   = out_data_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = '0;
        ram_wr_data     = ram_rd_data;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next  = op_t'(s_tuser);
                    key_next = s_tdata[KEY_W-1:0];
                    hnd_next = s_tdata[RW-1:KEY_W];
                    lo_next  = '0;
                    hi_next  = fill_reg;
                end
            end
            S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = mid[AW-1:0];
                    mid_next    = mid;
                end
            end
            S_CMP:
            begin
                if (rd_key < key_reg)
                begin
                    lo_next = mid_reg + CW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end
            S_CHECK_RD:
            begin
                // The lower bound may equal DEPTH; that read is then discarded.
                ram_rd_en    = 1'b1;
                ram_rd_addr  = lo_reg[AW-1:0];
                inrange_next = (lo_reg < fill_reg);
            end
            S_CHECK:
            begin
                res_handle_next = '0;
                res_pos_next    = '0;
                if (op_reg == OP_LOOKUP)
                begin
                    if (hit)
                    begin
                        res_status_next = STAT_FOUND;
                        res_handle_next = rd_hnd;
                        res_pos_next    = POS_W'(lo_reg);
                    end
                    else
                    begin
                        res_status_next = STAT_MISSING;
                    end
                end
                else if (hit)
                begin
                    res_status_next = STAT_DUPLICATE;
                end
                else if (fill_reg == CW'(DEPTH))
                begin
                    res_status_next = STAT_FULL;
                end
                else
                begin
                    ptr_next  = fill_reg;
                    pend_next = 1'b0;
                end
            end
            S_SHIFT:
            begin
                // Reads walk down from the top record while the record read in the
                // previous cycle is written one slot higher.
                if (pend_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = ptr_inc[AW-1:0];
                    ram_wr_data = ram_rd_data;
                end
                if (ptr_reg > lo_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_dec[AW-1:0];
                    ptr_next    = ptr_dec;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        ram_wr_en       = 1'b1;
                        ram_wr_addr     = lo_reg[AW-1:0];
                        ram_wr_data     = {hnd_reg, key_reg};
                        fill_next       = fill_reg + CW'(1);
                        res_status_next = STAT_INSERTED;
                        res_pos_next    = POS_W'(lo_reg);
                    end
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = res_status_reg;
                    out_data_next  = M_TDATA_W'({POS_W'(fill_reg), res_pos_reg,
                                                 res_handle_reg});
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        hnd_reg        <= hnd_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        ptr_reg        <= ptr_next;
        inrange_reg    <= inrange_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_pos_reg    <= res_pos_next;
        out_user_reg   <= out_user_next;
        out_data_reg   <= out_data_next;
    end

endmodule

// ----- hw/rtl/sktis_checker.sv -----
// Port-level checker for the sorted key table, bound to the top level.
`include "sorted_key_table_insert_search_unit_macros.svh"

module sktis_checker
    import sktis_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,   // search_key[29:0], record_handle[45:30]
    input logic                 s_tuser,   // opcode
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,   // found_handle, position, entry_count
    input logic [STATUS_W-1:0]  m_tuser    // status
);

    // A stalled result must not change under the consumer.
    `SKTIS_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // After a transaction is taken the unit is busy searching and cannot take a second one straight after it.
    `SKTIS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input taken twice in a row")

    // Only the five defined status codes may appear.
    `SKTIS_ASSERT_NOW(a_status_code, m_tvalid, m_tuser <= STAT_MISSING, "undefined status code")

    // The handle is zero unless a record was found.
    `SKTIS_ASSERT_NOW(a_handle_zero, m_tvalid && m_tuser != STAT_FOUND, m_tdata[15:0] == 16'd0, "handle set without a hit")

    // Position is zero when nothing was inserted or found.
    `SKTIS_ASSERT_NOW(a_pos_zero, m_tvalid && (m_tuser == STAT_DUPLICATE || m_tuser == STAT_FULL || m_tuser == STAT_MISSING), m_tdata[22:16] == 7'd0, "position set on a refused item")

    logic unused_ok;
    assign unused_ok = ^{s_tdata, s_tuser};

endmodule

bind sorted_key_table_insert_search_unit sktis_checker u_sktis_checker (.*);
